FILE: hw/rtl/per_resource_fifo_edf_waitlist_arbiter_top_defines.svh
// Assertion macros for the waiting-list arbiter.
// Included by the top level; no other dependencies.
`ifndef PER_RESOURCE_FIFO_EDF_WAITLIST_ARBITER_TOP_DEFINES_SVH
`define PER_RESOURCE_FIFO_EDF_WAITLIST_ARBITER_TOP_DEFINES_SVH

// Antecedent implies consequent on the same edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent on the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/wla_pkg.sv
// Shared types and constants for the waiting-list arbiter.
// No dependencies.
`default_nettype none
package wla_pkg;
   localparam int NumResources = 64;
   localparam int ListDepth    = 64;
   localparam int ResW   = 6;
   localparam int PosW   = 6;
   localparam int CntW   = 7;
   localparam int AddrW  = ResW + PosW;
   localparam int EntryW = 6 + 32 + 32;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   // controller -> datapath commands
   typedef struct packed {
      logic          load;      // capture request, read length
      logic          rd_en;     // issue entry read
      logic [PosW-1:0] rd_pos;
      logic          wr_en;
      logic          wr_from_req; // write request payload (else last read data)
      logic [PosW-1:0] wr_pos;
      logic          len_wr;
      logic [CntW-1:0] len_val;
      logic          scan_first; // compare data is at position 0
      logic          scan_step;  // compare data is valid
      logic          out_load;
      logic [1:0]    out_status;
      logic          out_query;
   } wla_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic [1:0]      cmd;
      logic [CntW-1:0] len;
      logic            id_match;   // read data requester equals request
   } wla_sts_type;
endpackage
`default_nettype wire

FILE: hw/rtl/per_resource_fifo_edf_waitlist_arbiter_top.sv
// Waiting-list arbiter with FIFO / earliest-deadline-first selection.
// Accepts one request beat on req_*, returns one result beat on rsp_*.
// Commands: add appends to the addressed list, remove deletes the first
// entry of a requester and compacts, query scans for the winner.
// An add writes its entry, unless the list is full, in the decode step and
// then loads its result; remove and query read a list of n entries with one
// entry RAM read per cycle before the result step. A new request is
// accepted in the cycle after a result is loaded.
// One request is in flight at a time; req_stall is high while working.
// The result register holds a beat while rsp_stall is high; the next
// request is taken meanwhile and waits at the result step.
// Reset empties all lists and sets policy_mode to FIFO; entry RAM
// contents need no clearing since only entries below a list length are read.
// csr_wr_en with csr_wr_data writes policy_mode; write it only when idle.
`default_nettype none
`include "per_resource_fifo_edf_waitlist_arbiter_top_defines.svh"
module per_resource_fifo_edf_waitlist_arbiter_top import wla_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [5:0]  req_resource_index,
   input  wire logic [5:0]  req_requester_id,
   input  wire logic [31:0] req_arrival_time,
   input  wire logic [31:0] req_deadline_time,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_is_turn,
   output logic             rsp_winner_valid,
   output logic [5:0]       rsp_winner_id,
   output logic [1:0]       rsp_status,
   output logic [6:0]       rsp_list_count
);
   logic policy_ff;
   wla_cmd_type cmd;
   wla_sts_type sts;

   // policy register
   always_ff @(posedge clock) begin
      if (reset) policy_ff <= 1'b0;
      else if (csr_wr_en) policy_ff <= csr_wr_data;
   end

   wla_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .cmd(cmd)
   );

   wla_datapath u_dp (
      .clock(clock), .reset(reset), .policy(policy_ff),
      .req_cmd(req_cmd), .req_resource_index(req_resource_index),
      .req_requester_id(req_requester_id), .req_arrival_time(req_arrival_time),
      .req_deadline_time(req_deadline_time),
      .cmd(cmd), .sts(sts),
      .rsp_is_turn(rsp_is_turn), .rsp_winner_valid(rsp_winner_valid),
      .rsp_winner_id(rsp_winner_id), .rsp_status(rsp_status),
      .rsp_list_count(rsp_list_count)
   );

   `ASSERT_IMPLY(a_turn_needs_winner, clock, reset, rsp_valid && rsp_is_turn, rsp_winner_valid)
   `ASSERT_IMPLY(a_count_bound, clock, reset, rsp_valid, rsp_list_count <= 7'd64)
   `ASSERT_NEXT(a_single_load, clock, reset, cmd.load, req_stall)
endmodule
`default_nettype wire

FILE: hw/rtl/wla_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module wla_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/wla_datapath.sv
// Datapath: entry RAM, list lengths, request capture, winner compare, result.
// Depends on wla_pkg and wla_ram.
`default_nettype none
module wla_datapath import wla_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        policy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [5:0]  req_resource_index,
   input  wire logic [5:0]  req_requester_id,
   input  wire logic [31:0] req_arrival_time,
   input  wire logic [31:0] req_deadline_time,
   input  wire wla_cmd_type cmd,
   output wla_sts_type      sts,
   output logic             rsp_is_turn,
   output logic             rsp_winner_valid,
   output logic [5:0]       rsp_winner_id,
   output logic [1:0]       rsp_status,
   output logic [6:0]       rsp_list_count
);
   logic [1:0]  cmd_ff;
   logic [ResW-1:0] res_ff;
   logic [5:0]  who_ff;
   logic [31:0] arr_ff, dl_ff;
   logic [NumResources-1:0] len_vld_ff;
   logic [CntW-1:0] len_rd_data;
   logic [CntW-1:0] cur_len;
   logic [EntryW-1:0] rd_data, wr_data;
   logic [5:0]  best_id_ff;
   logic [31:0] best_arr_ff, best_dl_ff;
   logic        beats;
   logic [5:0]  e_id;
   logic [31:0] e_arr, e_dl;

   assign {e_id, e_arr, e_dl} = rd_data;
   assign cur_len = len_vld_ff[res_ff] ? len_rd_data : '0;
   assign sts.cmd = cmd_ff;
   assign sts.len = cur_len;
   assign sts.id_match = (e_id == who_ff);

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_cmd;
         res_ff <= req_resource_index;
         who_ff <= req_requester_id;
         arr_ff <= req_arrival_time;
         dl_ff  <= req_deadline_time;
      end
   end

   // list lengths: RAM read on load, a list never written reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         len_vld_ff <= '0;
      end else if (cmd.len_wr) begin
         len_vld_ff[res_ff] <= 1'b1;
      end
   end

   wla_ram #(.Width(CntW), .Depth(NumResources)) u_len_ram (
      .clock  (clock),
      .wr_en  (cmd.len_wr),
      .wr_addr(res_ff),
      .wr_data(cmd.len_val),
      .rd_en  (cmd.load),
      .rd_addr(req_resource_index),
      .rd_data(len_rd_data)
   );

   assign wr_data = cmd.wr_from_req ? {who_ff, arr_ff, dl_ff} : rd_data;

   wla_ram #(.Width(EntryW), .Depth(NumResources * ListDepth)) u_ram (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr({res_ff, cmd.wr_pos}),
      .wr_data(wr_data),
      .rd_en  (cmd.rd_en),
      .rd_addr({res_ff, cmd.rd_pos}),
      .rd_data(rd_data)
   );

   // candidate beats current best
   always_comb begin
      if (!policy) beats = e_arr < best_arr_ff;
      else if (e_dl != best_dl_ff) beats = e_dl < best_dl_ff;
      else beats = e_arr < best_arr_ff;
   end

   // running best over the scan
   always_ff @(posedge clock) begin
      if (cmd.scan_step && (cmd.scan_first || beats)) begin
         best_id_ff  <= e_id;
         best_arr_ff <= e_arr;
         best_dl_ff  <= e_dl;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status     <= cmd.out_status;
         rsp_list_count <= cmd.len_val;
         rsp_winner_valid <= cmd.out_query;
         rsp_winner_id  <= cmd.out_query ? best_id_ff : 6'd0;
         rsp_is_turn    <= cmd.out_query && (best_id_ff == who_ff);
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/wla_ctrl.sv
// Controller: sequences add, remove (search and compact) and query scan.
// Depends on wla_pkg.
`default_nettype none
module wla_ctrl import wla_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   input  wire wla_sts_type sts,
   output wla_cmd_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_SEARCH, S_SHIFT, S_SCAN, S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic [CntW-1:0] pos_ff, pos_in;   // read position of data arriving now
   logic [CntW-1:0] rlen_ff, rlen_in; // result count
   logic [1:0] rst_ff, rst_in;        // result status
   logic qry_ff, qry_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CntW-1:0] nxt;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign nxt = pos_ff + 7'd1;

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      rlen_in = rlen_ff;
      rst_in = rst_ff;
      qry_in = qry_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      cmd.len_val = rlen_ff;
      cmd.out_status = rst_ff;
      cmd.out_query = qry_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            rst_in = ST_OK;
            qry_in = 1'b0;
            rlen_in = sts.len;
            pos_in = '0;
            unique case (sts.cmd)
               CMD_ADD: begin
                  if (sts.len >= CntW'(ListDepth)) begin
                     rst_in = ST_FULL;
                  end else begin
                     cmd.wr_en = 1'b1;
                     cmd.wr_from_req = 1'b1;
                     cmd.wr_pos = sts.len[PosW-1:0];
                     rlen_in = sts.len + 7'd1;
                  end
                  state_in = S_RESULT;
               end
               CMD_REMOVE: begin
                  if (sts.len == '0) begin
                     rst_in = ST_MISSING;
                     state_in = S_RESULT;
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in = S_SEARCH;
                  end
               end
               CMD_QUERY: begin
                  if (sts.len == '0) begin
                     state_in = S_RESULT;
                  end else begin
                     cmd.rd_en = 1'b1;
                     qry_in = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               default: state_in = S_RESULT;
            endcase
         end
         S_SEARCH: begin
            // data of pos_ff is on the read port
            if (sts.id_match) begin
               if (nxt >= rlen_ff) begin
                  rlen_in = rlen_ff - 7'd1;
                  state_in = S_RESULT;
               end else begin
                  cmd.rd_en = 1'b1;
                  cmd.rd_pos = nxt[PosW-1:0];
                  pos_in = nxt;
                  state_in = S_SHIFT;
               end
            end else if (nxt >= rlen_ff) begin
               rst_in = ST_MISSING;
               state_in = S_RESULT;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.rd_pos = nxt[PosW-1:0];
               pos_in = nxt;
            end
         end
         S_SHIFT: begin
            // move entry pos_ff down one place
            cmd.wr_en = 1'b1;
            cmd.wr_pos = 6'(pos_ff - 7'd1);
            if (nxt >= rlen_ff) begin
               rlen_in = rlen_ff - 7'd1;
               state_in = S_RESULT;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.rd_pos = nxt[PosW-1:0];
               pos_in = nxt;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.scan_first = (pos_ff == '0);
            if (nxt >= rlen_ff) begin
               state_in = S_RESULT;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.rd_pos = nxt[PosW-1:0];
               pos_in = nxt;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               cmd.len_wr = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff <= '0;
         rlen_ff <= '0;
         rst_ff <= ST_OK;
         qry_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         rlen_ff <= rlen_in;
         rst_ff <= rst_in;
         qry_ff <= qry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the waiting-list arbiter (FIFO / EDF selection).
// Depends on wla_pkg and per_resource_fifo_edf_waitlist_arbiter_top.
`default_nettype none
module tb_top import wla_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_ADD;
   logic [5:0]  req_resource_index = '0;
   logic [5:0]  req_requester_id = '0;
   logic [31:0] req_arrival_time = '0;
   logic [31:0] req_deadline_time = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_turn;
   logic        rsp_winner_valid;
   logic [5:0]  rsp_winner_id;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_list_count;

   typedef struct packed {
      logic       is_turn;
      logic       winner_valid;
      logic [5:0] winner_id;
      logic [1:0] status;
      logic [6:0] list_count;
   } verdict_type;

   // predictor state
   logic [5:0]  wl_req [NumResources][ListDepth];
   logic [31:0] wl_arr [NumResources][ListDepth];
   logic [31:0] wl_dl  [NumResources][ListDepth];
   int          wl_len [NumResources];
   logic        edf_mode = 1'b0;

   verdict_type pending_verdicts[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;      // no random idling in the last part

   per_resource_fifo_edf_waitlist_arbiter_top uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_cmd), .req_resource_index(req_resource_index),
      .req_requester_id(req_requester_id), .req_arrival_time(req_arrival_time),
      .req_deadline_time(req_deadline_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_is_turn(rsp_is_turn), .rsp_winner_valid(rsp_winner_valid),
      .rsp_winner_id(rsp_winner_id), .rsp_status(rsp_status),
      .rsp_list_count(rsp_list_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scheduling decision for one beat, updating the list copy.
   function automatic verdict_type schedule_step(logic [1:0] cmd, logic [5:0] r,
         logic [5:0] who, logic [31:0] arr, logic [31:0] dl);
      verdict_type v;
      int n, i, best;
      bit win;
      v = '0;
      n = wl_len[r];
      case (cmd)
         CMD_ADD: begin
            if (n >= ListDepth) begin
               v.status = ST_FULL;
            end else begin
               wl_req[r][n] = who; wl_arr[r][n] = arr; wl_dl[r][n] = dl;
               n++;
            end
         end
         CMD_REMOVE: begin
            i = 0;
            while (i < n && wl_req[r][i] != who) i++;
            if (i >= n) begin
               v.status = ST_MISSING;
            end else begin
               for (; i + 1 < n; i++) begin
                  wl_req[r][i] = wl_req[r][i+1];
                  wl_arr[r][i] = wl_arr[r][i+1];
                  wl_dl[r][i]  = wl_dl[r][i+1];
               end
               n--;
            end
         end
         CMD_QUERY: begin
            if (n > 0) begin
               best = 0;
               for (i = 1; i < n; i++) begin
                  if (!edf_mode) win = wl_arr[r][i] < wl_arr[r][best];
                  else if (wl_dl[r][i] != wl_dl[r][best])
                     win = wl_dl[r][i] < wl_dl[r][best];
                  else win = wl_arr[r][i] < wl_arr[r][best];
                  if (win) best = i;
               end
               v.winner_valid = 1'b1;
               v.winner_id = wl_req[r][best];
               v.is_turn = (wl_req[r][best] == who);
            end
         end
         default: ;
      endcase
      wl_len[r] = n;
      v.list_count = n[6:0];
      return v;
   endfunction

   // Send one request beat; the expectation is logged on acceptance.
   task automatic send_request(logic [1:0] cmd, logic [5:0] r, logic [5:0] who,
         logic [31:0] arr, logic [31:0] dl);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd; req_resource_index <= r; req_requester_id <= who;
      req_arrival_time <= arr; req_deadline_time <= dl;
      do @(posedge clock); while (req_stall);
      pending_verdicts.push_back(schedule_step(cmd, r, who, arr, dl));
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain_results();
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_policy(logic mode);
      drain_results();
      csr_wr_en <= 1'b1; csr_wr_data <= mode;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      edf_mode = mode;
   endtask

   // Result channel stall bursts.
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 13);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // Result checker and watchdog.
   always @(posedge clock) begin
      verdict_type e;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $error("result beat with no expectation");
            errors++;
         end else begin
            e = pending_verdicts.pop_front();
            if (rsp_is_turn !== e.is_turn) begin
               $error("is_turn exp %0d got %0d", e.is_turn, rsp_is_turn); errors++;
            end
            if (rsp_winner_valid !== e.winner_valid) begin
               $error("winner_valid exp %0d got %0d", e.winner_valid, rsp_winner_valid);
               errors++;
            end
            if (rsp_winner_id !== e.winner_id) begin
               $error("winner_id exp %0d got %0d", e.winner_id, rsp_winner_id); errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); errors++;
            end
            if (rsp_list_count !== e.list_count) begin
               $error("list_count exp %0d got %0d", e.list_count, rsp_list_count);
               errors++;
            end
         end
      end
   end

   function automatic logic [31:0] rand_time();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 7);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // Empty-list cases, unused command, and the extremes of every field.
   task automatic test_edges();
      send_request(CMD_QUERY, 6'd0, 6'd0, '0, '0);
      send_request(CMD_REMOVE, 6'd63, 6'd63, '0, '0);
      send_request(2'd3, 6'd5, 6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_ADD, 6'd63, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_ADD, 6'd63, 6'd0, 32'h0, 32'hFFFF_FFFF);
      send_request(CMD_ADD, 6'd63, 6'd21, 32'h0, 32'h0);
      send_request(CMD_QUERY, 6'd63, 6'd0, '0, '0);
      send_request(CMD_QUERY, 6'd63, 6'd63, '0, '0);
      send_request(2'd3, 6'd63, 6'd42, 32'h5555_5555, 32'hAAAA_AAAA);
      send_request(CMD_REMOVE, 6'd63, 6'd42, '0, '0);
      send_request(CMD_REMOVE, 6'd63, 6'd0, '0, '0);
      send_request(CMD_QUERY, 6'd63, 6'd21, '0, '0);
   endtask

   // Fill one list past its depth, then empty it.
   task automatic test_full_list();
      for (int i = 0; i < ListDepth + 2; i++)
         send_request(CMD_ADD, 6'd7, i[5:0], rand_time(), rand_time());
      send_request(CMD_QUERY, 6'd7, 6'd3, '0, '0);
      for (int i = 0; i < ListDepth; i++)
         send_request(CMD_REMOVE, 6'd7, i[5:0], '0, '0);
   endtask

   // Ties on deadline and arrival under the given policy.
   task automatic test_ties(logic mode);
      write_policy(mode);
      send_request(CMD_ADD, 6'd9, 6'd1, 32'd5, 32'd9);
      send_request(CMD_ADD, 6'd9, 6'd2, 32'd5, 32'd9);
      send_request(CMD_ADD, 6'd9, 6'd3, 32'd4, 32'd9);
      send_request(CMD_ADD, 6'd9, 6'd4, 32'd8, 32'd2);
      send_request(CMD_QUERY, 6'd9, 6'd4, '0, '0);
      send_request(CMD_REMOVE, 6'd9, 6'd4, '0, '0);
      send_request(CMD_QUERY, 6'd9, 6'd3, '0, '0);
      for (int i = 1; i < 4; i++) send_request(CMD_REMOVE, 6'd9, i[5:0], '0, '0);
   endtask

   // Random traffic over a few hot resources with small id sets.
   task automatic test_random(int count);
      logic [1:0] c;
      logic [5:0] r, who;
      for (int k = 0; k < count; k++) begin
         if (k % 200 == 199) write_policy(1'($urandom_range(0, 1)));
         if (k == count - 100) quiet = 1'b1;
         r = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
         who = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
         case ($urandom_range(0, 19))
            0: c = 2'd3;
            1, 2, 3, 4, 5, 6, 7: c = CMD_ADD;
            8, 9, 10, 11, 12: c = CMD_REMOVE;
            default: c = CMD_QUERY;
         endcase
         send_request(c, r, who, rand_time(), rand_time());
      end
   endtask

   initial begin
      for (int i = 0; i < NumResources; i++) wl_len[i] = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_edges();
      test_full_list();
      test_ties(1'b1);
      test_ties(1'b0);
      write_policy(1'b1);
      test_random(785);
      drain_results();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+hw/rtl
hw/rtl/wla_pkg.sv
hw/rtl/wla_ram.sv
hw/rtl/wla_datapath.sv
hw/rtl/wla_ctrl.sv
hw/rtl/per_resource_fifo_edf_waitlist_arbiter_top.sv
tb/tb_top.sv
